// ===== rtl/core/q2e_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and the arctangent table for the quaternion to Euler converter.
package q2e_pkg;

  // Angle format and CORDIC depth
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 24;
  localparam int TAB_LEN         = 32;

  // Field widths
  localparam int IN_W   = 32;
  localparam int ANG_W  = 17;
  localparam int ROLL_W = 16;

  // Datapath widths
  localparam int Q_W   = 32;   // Q2.30 component or root
  localparam int CV_W  = 48;   // CORDIC vector, Q40 plus growth
  localparam int Z_W   = 36;   // CORDIC angle, radians Q32
  localparam int TAB_W = 34;
  localparam int ZL_W  = 17;   // low part of the angle for the degree product

  // Pipeline depths
  localparam int SQRT_STAGES = 32;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 3;

  // Fixed-point constants
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
  localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [26:0] DEG_K   = 27'sd60078979;   // 180/pi in Q20
  localparam logic [25:0]        DEG_K_U = 26'd60078979;
  localparam int DEG_SHIFT = 52 - ANGLE_FRAC_BITS;
  localparam logic signed [63:0] DEG_RND = 64'sd1 <<< (DEG_SHIFT - 1);
  localparam logic signed [ANG_W-1:0] LIM180 = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] LIM90  = ANG_W'(90 << ANGLE_FRAC_BITS);

  // atan(2^-i) in radians, Q32
  localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
    34'd3373259426, 34'd1991351318, 34'd1052175346, 34'd534100635,
    34'd268086748,  34'd134174063,  34'd67103403,   34'd33553749,
    34'd16777131,   34'd8388597,    34'd4194303,    34'd2097152,
    34'd1048576,    34'd524288,     34'd262144,     34'd131072,
    34'd65536,      34'd32768,      34'd16384,      34'd8192,
    34'd4096,       34'd2048,       34'd1024,       34'd512,
    34'd256,        34'd128,        34'd64,         34'd32,
    34'd16,         34'd8,          34'd4,          34'd2
  };

endpackage

// ===== rtl/core/q2e_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for quaternion items and Euler angle items.
interface q2e_in_if
  import q2e_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   frame_valid;
  logic signed [IN_W-1:0] quat_x;
  logic signed [IN_W-1:0] quat_y;
  logic signed [IN_W-1:0] quat_z;

  modport source (output valid, frame_valid, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, frame_valid, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if
  import q2e_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     angles_valid;
  logic signed [ANG_W-1:0]  pitch_deg;
  logic signed [ROLL_W-1:0] roll_deg;
  logic signed [ANG_W-1:0]  yaw_deg;

  modport source (output valid, angles_valid, pitch_deg, roll_deg, yaw_deg, input ready);
  modport sink   (input valid, angles_valid, pitch_deg, roll_deg, yaw_deg, output ready);
endinterface

// ===== rtl/core/q2e_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
module q2e_sqrt
  import q2e_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [63:0]    rad_i,
  output logic [Q_W-1:0] root_o
);

  logic [63:0] rem_r [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    logic [63:0] rem_nxt;
    logic [63:0] res_nxt;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    // restoring step: try to set this root bit
    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root_o = res_r[SQRT_STAGES-1][Q_W-1:0];

endmodule

// ===== rtl/core/q2e_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC atan2 in vectoring mode with conversion to saturated degrees.
module q2e_cordic
  import q2e_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CV_W-1:0]  x_i,
  input  logic signed [CV_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] lim_i,
  output logic signed [ANG_W-1:0] deg_o
);

  localparam logic signed [Z_W-1:0] HALF_PI = signed'(Z_W'({ATAN_TAB[0], 1'b0}));

  logic signed [CV_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CV_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS+1];
  logic                   zero_r [CORDIC_STEPS+1];

  logic signed [CV_W-1:0] x0_nxt;
  logic signed [CV_W-1:0] y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  // quadrant fold: left half-plane vectors are turned by a quarter turn
  always_comb begin
    x0_nxt = x_i;
    y0_nxt = y_i;
    z0_nxt = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_nxt = y_i;
        y0_nxt = -x_i;
        z0_nxt = HALF_PI;
      end else begin
        x0_nxt = -y_i;
        y0_nxt = x_i;
        z0_nxt = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      zero_r[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] ANG = signed'(Z_W'(ATAN_TAB[i]));
    logic signed [CV_W-1:0] dx;
    logic signed [CV_W-1:0] dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ANG;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ANG;
        end
      end
    end
  end

  // degree scaling, split into two partial products
  logic signed [Z_W-1:0]      z_fin;
  logic signed [Z_W-ZL_W-1:0] z_hi;
  logic [ZL_W-1:0]            z_lo;
  logic signed [45:0]         ph_r;
  logic [42:0]                pl_r;

  assign z_fin = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];
  assign z_hi  = z_fin[Z_W-1:ZL_W];
  assign z_lo  = z_fin[ZL_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= z_hi * DEG_K;
      pl_r <= z_lo * DEG_K_U;
    end
  end

  // recombine, round, saturate
  logic signed [63:0]      sum;
  logic signed [63:0]      scaled;
  logic signed [63:0]      lim_ext;
  logic signed [ANG_W-1:0] deg_nxt;
  logic signed [ANG_W-1:0] deg_r;

  always_comb begin
    sum     = (64'(ph_r) <<< ZL_W) + signed'(64'(pl_r)) + DEG_RND;
    scaled  = sum >>> DEG_SHIFT;
    lim_ext = 64'(lim_i);
    if (scaled > lim_ext) begin
      deg_nxt = lim_i;
    end else if (scaled < -lim_ext) begin
      deg_nxt = -lim_i;
    end else begin
      deg_nxt = scaled[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= deg_nxt;
    end
  end

  assign deg_o = deg_r;

endmodule

// ===== rtl/core/quaternion_to_euler_angles_top.sv =====
`timescale 1ns / 1ps
// Top level: quaternion vector part to pitch, roll and yaw in degrees.
//
// Usage:
//   in_ch carries one orientation frame per item: frame_valid and the Q2.30
//   components quat_x, quat_y, quat_z. out_ch returns one item per input
//   item, in order: angles_valid, pitch_deg, roll_deg, yaw_deg (degrees
//   times 256). A frame without a quaternion gives angles_valid = 0 and
//   zero angles.
//   One item is taken every cycle while the pipeline is not held: the path
//   is a straight pipeline of 3 product stages, a 32-stage square root,
//   4 more product stages, a second 32-stage square root and three 27-stage
//   CORDIC units running side by side, closed by an output register.
//   Reset clears every stage valid bit and the output valid; no clearing
//   pass is needed. When out_ch.ready is low while a result waits, the whole
//   pipeline holds and in_ch.ready drops with it; nothing is lost or repeated.
module quaternion_to_euler_angles_top
  import q2e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  q2e_in_if.sink    in_ch,
  q2e_out_if.source out_ch
);

  typedef struct packed {
    logic vld;
    logic frm;
  } ctl_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  q1;
    logic signed [Q_W-1:0]  q2;
    logic signed [Q_W-1:0]  q3;
    logic signed [63:0]     p23;
    logic signed [63:0]     p12;
    logic signed [63:0]     p31;
    logic signed [CV_W-1:0] xp;
    logic signed [CV_W-1:0] xy;
  } sb1_t;

  typedef struct packed {
    logic signed [CV_W-1:0] yp;
    logic signed [CV_W-1:0] xp;
    logic signed [CV_W-1:0] yy;
    logic signed [CV_W-1:0] xy;
    logic signed [Q_W-1:0]  s30;
  } sb2_t;

  function automatic logic signed [Q_W-1:0] sat_q30(input logic signed [IN_W-1:0] v);
    logic signed [Q_W-1:0] r;
    r = v;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: saturate components
  ctl_t                  c1_r;
  logic signed [Q_W-1:0] q1_s1_r, q2_s1_r, q3_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= '{vld: in_ch.valid, frm: in_ch.frame_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_s1_r <= sat_q30(in_ch.quat_x);
      q2_s1_r <= sat_q30(in_ch.quat_y);
      q3_s1_r <= sat_q30(in_ch.quat_z);
    end
  end

  // Stage 2: squares and cross products
  ctl_t                  c2_r;
  logic signed [Q_W-1:0] q1_s2_r, q2_s2_r, q3_s2_r;
  logic signed [63:0]    sq1_r, sq2_r, sq3_r, p23_r, p12_r, p31_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else if (en) begin
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_s2_r <= q1_s1_r;
      q2_s2_r <= q2_s1_r;
      q3_s2_r <= q3_s1_r;
      sq1_r   <= q1_s1_r * q1_s1_r;
      sq2_r   <= q2_s1_r * q2_s1_r;
      sq3_r   <= q3_s1_r * q3_s1_r;
      p23_r   <= q2_s1_r * q3_s1_r;
      p12_r   <= q1_s1_r * q2_s1_r;
      p31_r   <= q3_s1_r * q1_s1_r;
    end
  end

  // Stage 3: radicand for Q0 and the two atan2 x terms
  ctl_t               c3_r;
  sb1_t               s3_r;
  logic [63:0]        rad_r;
  logic signed [63:0] rad_full;
  logic signed [63:0] xp_full;
  logic signed [63:0] xy_full;
  logic signed [63:0] xp_q40;
  logic signed [63:0] xy_q40;

  always_comb begin
    rad_full = ONE_Q60 - sq1_r - sq2_r - sq3_r;
    xp_full  = ONE_Q60 - ((sq1_r + sq2_r) <<< 1);
    xy_full  = ONE_Q60 - ((sq2_r + sq3_r) <<< 1);
    xp_q40   = xp_full >>> 20;
    xy_q40   = xy_full >>> 20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r <= '0;
    end else if (en) begin
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r   <= (rad_full < 0) ? '0 : unsigned'(rad_full);
      s3_r.q1  <= q1_s2_r;
      s3_r.q2  <= q2_s2_r;
      s3_r.q3  <= q3_s2_r;
      s3_r.p23 <= p23_r;
      s3_r.p12 <= p12_r;
      s3_r.p31 <= p31_r;
      s3_r.xp  <= xp_q40[CV_W-1:0];
      s3_r.xy  <= xy_q40[CV_W-1:0];
    end
  end

  // Q0 square root with matching side line
  logic [Q_W-1:0] q0_root;
  ctl_t           ctl1_line_r [SQRT_STAGES];
  sb1_t           sb1_line_r  [SQRT_STAGES];

  q2e_sqrt u_sqrt_q0 (
    .clk    (clk),
    .en     (en),
    .rad_i  (rad_r),
    .root_o (q0_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
        ctl1_line_r[i] <= '0;
      end
    end else if (en) begin
      ctl1_line_r[0] <= c3_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        ctl1_line_r[i] <= ctl1_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_line_r[0] <= s3_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sb1_line_r[i] <= sb1_line_r[i-1];
      end
    end
  end

  // Stage 4: products with Q0
  ctl_t                  c4_r;
  sb1_t                  s4_r;
  logic signed [63:0]    q0q1_r, q0q2_r, q0q3_r;
  logic signed [Q_W-1:0] q0_s;

  assign q0_s = signed'(q0_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
    end else if (en) begin
      c4_r <= ctl1_line_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r   <= sb1_line_r[SQRT_STAGES-1];
      q0q1_r <= q0_s * sb1_line_r[SQRT_STAGES-1].q1;
      q0q2_r <= q0_s * sb1_line_r[SQRT_STAGES-1].q2;
      q0q3_r <= q0_s * sb1_line_r[SQRT_STAGES-1].q3;
    end
  end

  // Stage 5: atan2 y terms and the clamped asin argument
  ctl_t               c5_r;
  sb2_t               s5_r;
  logic signed [63:0] yp_full;
  logic signed [63:0] yy_full;
  logic signed [63:0] s_full;
  logic signed [63:0] s_clamp;
  logic signed [63:0] yp_q40;
  logic signed [63:0] yy_q40;
  logic signed [63:0] s_q30;

  always_comb begin
    yp_full = (q0q1_r + s4_r.p23) <<< 1;
    yy_full = (q0q3_r + s4_r.p12) <<< 1;
    s_full  = (q0q2_r - s4_r.p31) <<< 1;
    if (s_full > ONE_Q60) begin
      s_clamp = ONE_Q60;
    end else if (s_full < -ONE_Q60) begin
      s_clamp = -ONE_Q60;
    end else begin
      s_clamp = s_full;
    end
    yp_q40 = yp_full >>> 20;
    yy_q40 = yy_full >>> 20;
    s_q30  = s_clamp >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r <= '0;
    end else if (en) begin
      c5_r <= c4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r.yp  <= yp_q40[CV_W-1:0];
      s5_r.yy  <= yy_q40[CV_W-1:0];
      s5_r.xp  <= s4_r.xp;
      s5_r.xy  <= s4_r.xy;
      s5_r.s30 <= s_q30[Q_W-1:0];
    end
  end

  // Stage 6: square of the asin argument
  ctl_t               c6_r;
  sb2_t               s6_r;
  logic signed [63:0] ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c6_r <= '0;
    end else if (en) begin
      c6_r <= c5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r <= s5_r;
      ss_r <= s5_r.s30 * s5_r.s30;
    end
  end

  // Stage 7: radicand for the cosine term
  ctl_t               c7_r;
  sb2_t               s7_r;
  logic [63:0]        cr_r;
  logic signed [63:0] cr_full;

  assign cr_full = ONE_Q60 - ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c7_r <= '0;
    end else if (en) begin
      c7_r <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= s6_r;
      cr_r <= (cr_full < 0) ? '0 : unsigned'(cr_full);
    end
  end

  // Cosine square root with matching side line
  logic [Q_W-1:0] c_root;
  ctl_t           ctl2_line_r [SQRT_STAGES];
  sb2_t           sb2_line_r  [SQRT_STAGES];

  q2e_sqrt u_sqrt_cos (
    .clk    (clk),
    .en     (en),
    .rad_i  (cr_r),
    .root_o (c_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
        ctl2_line_r[i] <= '0;
      end
    end else if (en) begin
      ctl2_line_r[0] <= c7_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        ctl2_line_r[i] <= ctl2_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_line_r[0] <= s7_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sb2_line_r[i] <= sb2_line_r[i-1];
      end
    end
  end

  // Three CORDIC units: pitch, roll (asin as atan2), yaw
  sb2_t                    sb2_last;
  logic signed [CV_W-1:0]  roll_y;
  logic signed [CV_W-1:0]  roll_x;
  logic signed [ANG_W-1:0] pitch_res;
  logic signed [ANG_W-1:0] roll_res;
  logic signed [ANG_W-1:0] yaw_res;

  assign sb2_last = sb2_line_r[SQRT_STAGES-1];
  assign roll_y   = CV_W'(sb2_last.s30) <<< 10;
  assign roll_x   = signed'(CV_W'(c_root)) <<< 10;

  q2e_cordic u_cordic_pitch (
    .clk   (clk),
    .en    (en),
    .x_i   (sb2_last.xp),
    .y_i   (sb2_last.yp),
    .lim_i (LIM180),
    .deg_o (pitch_res)
  );

  q2e_cordic u_cordic_roll (
    .clk   (clk),
    .en    (en),
    .x_i   (roll_x),
    .y_i   (roll_y),
    .lim_i (LIM90),
    .deg_o (roll_res)
  );

  q2e_cordic u_cordic_yaw (
    .clk   (clk),
    .en    (en),
    .x_i   (sb2_last.xy),
    .y_i   (sb2_last.yy),
    .lim_i (LIM180),
    .deg_o (yaw_res)
  );

  ctl_t ctl3_line_r [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_LAT; i++) begin
        ctl3_line_r[i] <= '0;
      end
    end else if (en) begin
      ctl3_line_r[0] <= ctl2_line_r[SQRT_STAGES-1];
      for (int i = 1; i < CORDIC_LAT; i++) begin
        ctl3_line_r[i] <= ctl3_line_r[i-1];
      end
    end
  end

  // Output register; frames without a quaternion read as zero angles
  ctl_t                     c_last;
  logic                     angles_valid_r;
  logic signed [ANG_W-1:0]  pitch_r;
  logic signed [ROLL_W-1:0] roll_r;
  logic signed [ANG_W-1:0]  yaw_r;

  assign c_last = ctl3_line_r[CORDIC_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles_valid_r <= c_last.frm;
      pitch_r        <= c_last.frm ? pitch_res : '0;
      roll_r         <= c_last.frm ? roll_res[ROLL_W-1:0] : '0;
      yaw_r          <= c_last.frm ? yaw_res : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.angles_valid = angles_valid_r;
  assign out_ch.pitch_deg    = pitch_r;
  assign out_ch.roll_deg     = roll_r;
  assign out_ch.yaw_deg      = yaw_r;

endmodule

// ===== test/q2e_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench package: the result item type shared by the predictor and the checker.
package q2e_tb_pkg;
  import q2e_pkg::*;

  // One expected or observed result item
  typedef struct packed {
    logic                     angles_valid;
    logic signed [ANG_W-1:0]  pitch_deg;
    logic signed [ROLL_W-1:0] roll_deg;
    logic signed [ANG_W-1:0]  yaw_deg;
  } euler_t;
endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench: quaternion items in, Euler angles checked against an integer predictor.
module testbench;
  import q2e_pkg::*;
  import q2e_tb_pkg::*;

  localparam longint LIMIT_CYC = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cyc = 0;
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_invalid = 0;

  q2e_in_if  in_ch ();
  q2e_out_if out_ch ();

  quaternion_to_euler_angles_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Arctangent table rebuilt from the alternating series
  longint atan_q32 [TAB_LEN];

  function automatic longint atan_inv_q40(longint n);
    longint p, sum, k, term;
    p = (64'sd1 <<< 40) / n;
    sum = 0;
    k = 0;
    while (p > 0) begin
      term = p / (2 * k + 1);
      sum += (k[0]) ? -term : term;
      p = p / n / n;
      k++;
    end
    return sum;
  endfunction

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan2_q32(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 2 * atan_q32[0];
      end else begin
        x = -y; y = t; z = -2 * atan_q32[0];
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q32[i];
      end else begin
        x -= dx; y += dy; z -= atan_q32[i];
      end
    end
    return z;
  endfunction

  function automatic longint rad_to_deg(longint z, longint lim);
    longint r;
    r = fshr(z * 60078979 + (64'sd1 <<< (DEG_SHIFT - 1)), DEG_SHIFT);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint clamp_q30(logic [31:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
    if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
    return v;
  endfunction

  function automatic euler_t predict_angles(logic fv, logic [31:0] rx, logic [31:0] ry,
                                            logic [31:0] rz);
    euler_t e;
    longint q1, q2, q3, q0, s1, s2, s3, rd, y, x, s, c, sq, lim180, lim90;
    e = '0;
    if (!fv) return e;
    lim180 = 180 <<< ANGLE_FRAC_BITS;
    lim90 = 90 <<< ANGLE_FRAC_BITS;
    q1 = clamp_q30(rx);
    q2 = clamp_q30(ry);
    q3 = clamp_q30(rz);
    s1 = q1 * q1; s2 = q2 * q2; s3 = q3 * q3;
    rd = ONE_Q60 - s1 - s2 - s3;
    if (rd < 0) rd = 0;
    q0 = root64(rd);
    y = 2 * (q0 * q1 + q2 * q3);
    x = ONE_Q60 - 2 * (s1 + s2);
    e.pitch_deg = ANG_W'(rad_to_deg(atan2_q32(fshr(y, 20), fshr(x, 20)), lim180));
    s = 2 * (q0 * q2 - q3 * q1);
    if (s > ONE_Q60) s = ONE_Q60;
    if (s < -ONE_Q60) s = -ONE_Q60;
    s = fshr(s, 30);
    sq = ONE_Q60 - s * s;
    if (sq < 0) sq = 0;
    c = root64(sq);
    e.roll_deg = ROLL_W'(rad_to_deg(atan2_q32(s * 1024, c * 1024), lim90));
    y = 2 * (q0 * q3 + q1 * q2);
    x = ONE_Q60 - 2 * (s2 + s3);
    e.yaw_deg = ANG_W'(rad_to_deg(atan2_q32(fshr(y, 20), fshr(x, 20)), lim180));
    e.angles_valid = 1'b1;
    return e;
  endfunction

  // Expected angle items, oldest first
  euler_t angles_due [$];

  // Directed rows; chk marks a hand-typed expectation
  typedef struct {
    logic        fv;
    logic [31:0] qx, qy, qz;
    logic        chk;
    euler_t      exp_e;
  } row_t;

  localparam logic [31:0] P1 = 32'h4000_0000;
  localparam logic [31:0] M1 = 32'hC000_0000;
  localparam logic [31:0] H  = 32'h2D41_3CCD;   // ~sqrt(1/2)

  row_t rows [] = '{
    '{1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '0},
    '{1'b1, 32'h0, 32'h0, 32'h0, 1'b1, '{1'b1, 17'sd0, 16'sd0, 17'sd0}},
    '{1'b1, P1, 32'h0, 32'h0, 1'b0, '0},
    '{1'b1, M1, 32'h0, 32'h0, 1'b0, '0},
    '{1'b1, 32'h0, P1, 32'h0, 1'b0, '0},
    '{1'b1, 32'h0, M1, 32'h0, 1'b0, '0},
    '{1'b1, 32'h0, 32'h0, P1, 1'b0, '0},
    '{1'b1, 32'h0, 32'h0, M1, 1'b0, '0},
    '{1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
    '{1'b1, 32'h8000_0000, 32'h0, 32'h0, 1'b0, '0},
    '{1'b1, P1, P1, P1, 1'b0, '0},
    '{1'b1, M1, M1, M1, 1'b0, '0},
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b1, 32'h0, H, 32'h0, 1'b0, '0},
    '{1'b1, 32'h0, H, H, 1'b0, '0},
    '{1'b1, H, 32'h0, H, 1'b0, '0},
    '{1'b1, 32'h1, 32'hFFFF_FFFF, 32'h1, 1'b0, '0},
    '{1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 1'b0, '0},
    '{1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 1'b0, '0},
    '{1'b0, 32'h1234_5678, 32'h0, 32'h0, 1'b1, '0}
  };

  // Random quaternion component: mostly near a unit sphere, sometimes wild
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1)) ? P1 : M1;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 32'h4000_0000)) -
                          ($urandom_range(0, 1) ? 0 : 32'sh2000_0000));
    endcase
  endfunction

  task automatic send_item(logic fv, logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                           logic chk, euler_t exp_e);
    euler_t e;
    in_ch.valid       <= 1'b1;
    in_ch.frame_valid <= fv;
    in_ch.quat_x      <= qx;
    in_ch.quat_y      <= qy;
    in_ch.quat_z      <= qz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e = chk ? exp_e : predict_angles(fv, qx, qy, qz);
    angles_due.push_back(e);
    n_sent++;
  endtask

  // Stimulus: directed rows, then random bursts with gaps
  initial begin
    int burst;
    euler_t nil;
    nil = '0;
    in_ch.valid = 1'b0;
    in_ch.frame_valid = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    atan_q32[0] = (atan_inv_q40(2) + atan_inv_q40(3) + 128) >>> 8;
    for (int i = 1; i < TAB_LEN; i++) atan_q32[i] = (atan_inv_q40(64'sd1 <<< i) + 128) >>> 8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].fv, rows[i].qx, rows[i].qy, rows[i].qz,
                                rows[i].chk, rows[i].exp_e);
    while (n_sent < 1150) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_item($urandom_range(0, 11) != 0, rand_comp(), rand_comp(),
                               rand_comp(), 1'b0, nil);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d quaternion items (%0d invalid frames), checked %0d angle items.",
             n_sent, n_invalid, n_got);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Receiver stall pattern: long ready stretches mixed with random stalls
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if ((cyc % 1024) < 300) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Checker
  always @(posedge clk) begin
    euler_t got, want;
    cyc <= cyc + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.angles_valid, out_ch.pitch_deg, out_ch.roll_deg, out_ch.yaw_deg};
      if (angles_due.size() == 0) begin
        $error("angle item with none expected");
        errors++;
      end else begin
        want = angles_due.pop_front();
        n_got++;
        if (!want.angles_valid) n_invalid++;
        if (got.angles_valid !== want.angles_valid) begin
          $error("angles_valid exp %0d got %0d", want.angles_valid, got.angles_valid);
          errors++;
        end
        if (got.pitch_deg !== want.pitch_deg) begin
          $error("pitch_deg exp %0d got %0d", want.pitch_deg, got.pitch_deg);
          errors++;
        end
        if (got.roll_deg !== want.roll_deg) begin
          $error("roll_deg exp %0d got %0d", want.roll_deg, got.roll_deg);
          errors++;
        end
        if (got.yaw_deg !== want.yaw_deg) begin
          $error("yaw_deg exp %0d got %0d", want.yaw_deg, got.yaw_deg);
          errors++;
        end
      end
    end
    if (cyc > LIMIT_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end
endmodule
